// ===== src/block_padding_pad_strip_assert.svh =====
// assertion macros for the block padding unit checker
`ifndef BLOCK_PADDING_PAD_STRIP_ASSERT_SVH
`define BLOCK_PADDING_PAD_STRIP_ASSERT_SVH

// property checked on every clock edge outside reset
`define BPAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// signal stays unchanged while a valid item is stalled
`define BPAD_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> $stable(sig)) else $error(msg);

// property checked on every clock edge, reset included
`define BPAD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/bpad_pkg.sv =====
// shared types and constants of the block padding unit
package bpad_pkg;

  // width of a byte position inside a block
  localparam int unsigned POS_W = 6;

  // lfsr feedback taps for random fill
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // direction codes
  localparam logic DIR_PAD   = 1'b0;
  localparam logic DIR_STRIP = 1'b1;

  typedef enum logic [1:0] {
    SCH_ZERO  = 2'd0,
    SCH_ANSI  = 2'd1,
    SCH_PKCS7 = 2'd2,
    SCH_ISO   = 2'd3
  } scheme_e;

  typedef enum logic [1:0] {
    REG_DIRECTION   = 2'd0,
    REG_PAD_SCHEME  = 2'd1,
    REG_BLOCK_BYTES = 2'd2,
    REG_FILL_SEED   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       is_fill;
    logic [7:0] trim_count;
  } out_item_t;

  // configuration seen by the front end
  typedef struct packed {
    logic       direction;
    scheme_e    pad_scheme;
    logic [6:0] block_bytes;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [7:0]       data_byte;
    logic             out_last;
    logic [7:0]       trim_count;
    logic [POS_W-1:0] fill_cnt;
    scheme_e          pad_scheme;
  } cmd_t;

endpackage

// ===== src/block_padding_pad_strip.sv =====
// top level of the byte-serial block padding and strip unit
//
//   channel   signals                              carries
//   in        in_valid_i / in_ready_o / in_item_i   message byte, last flag
//   out       out_valid_o / out_ready_i / out_item_o byte, last, fill flag, trim
//   cfg       cfg_we_i / cfg_idx_i / cfg_wdata_i     register writes, no wait
//
// a byte without fill is a single result; a padded final byte holds the back end
// for P fill bytes more (up to block size - 1), one result per cycle while not stalled.
// two-entry queue between front and back; the front takes a byte per cycle
// while the queue has room. each byte passes the queue, then the output register.
// reset clears message state, queue and output valid; lfsr reloads on seed write.
module block_padding_pad_strip #(
  parameter int unsigned MAX_BLOCK_BYTES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bpad_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bpad_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i
);

  logic                direction_q;
  bpad_pkg::scheme_e   scheme_q;
  logic [6:0]          bbytes_q;
  logic                seed_we;
  bpad_pkg::cfg_t      cfg;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_empty;
  bpad_pkg::cmd_t      push_cmd;
  bpad_pkg::cmd_t      head_cmd;

  assign seed_we = cfg_we_i && bpad_pkg::reg_idx_e'(cfg_idx_i) == bpad_pkg::REG_FILL_SEED;

  assign cfg.direction   = direction_q;
  assign cfg.pad_scheme  = scheme_q;
  assign cfg.block_bytes = bbytes_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= bpad_pkg::DIR_PAD;
      scheme_q    <= bpad_pkg::SCH_PKCS7;
      bbytes_q    <= 7'd16;
    end else if (cfg_we_i) begin
      case (bpad_pkg::reg_idx_e'(cfg_idx_i))
        bpad_pkg::REG_DIRECTION:   direction_q <= cfg_wdata_i[0];
        bpad_pkg::REG_PAD_SCHEME:  scheme_q    <= bpad_pkg::scheme_e'(cfg_wdata_i[1:0]);
        bpad_pkg::REG_BLOCK_BYTES: bbytes_q    <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  bpad_front #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  bpad_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  bpad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_we_i   (seed_we),
    .seed_i      (cfg_wdata_i),
    .cmd_i       (head_cmd),
    .cmd_valid_i (!q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== src/bpad_front.sv =====
// front end: message tracking, strip check and fill length per item
module bpad_front #(
  parameter int unsigned MAX_BLOCK_BYTES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpad_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bpad_pkg::in_item_t  in_item_i,
  input  logic                q_full_i,
  output logic                push_o,
  output bpad_pkg::cmd_t      cmd_o
);

  localparam int unsigned PW = bpad_pkg::POS_W;
  localparam logic [6:0] MaxB = 7'(MAX_BLOCK_BYTES);

  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]    seen_q, seen_d;
  logic [7:0]    prev_q, prev_d;
  logic [7:0]    eq_q, eq_d;
  logic [7:0]    zero_q, zero_d;

  logic [6:0] bsize;
  logic [6:0] next_pos;
  logic [6:0] fill_len;
  logic [7:0] d;
  logic       last;
  logic       pad;
  logic [7:0] trim;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? 8'hFF : v + 8'd1;
  endfunction

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign d          = in_item_i.data_byte;
  assign last       = in_item_i.last_byte;

  // block size clamp and next position
  always_comb begin
    if (cfg_i.block_bytes == 7'd0) begin
      bsize = 7'd1;
    end else if (cfg_i.block_bytes > MaxB) begin
      bsize = MaxB;
    end else begin
      bsize = cfg_i.block_bytes;
    end
    next_pos = 7'(pos_q) + 7'd1;
    if (next_pos >= bsize) begin
      next_pos = 7'd0;
    end
    fill_len = bsize - next_pos;
  end

  // running counts
  always_comb begin
    seen_d = sat_inc(seen_q);
    eq_d   = (seen_q != 8'd0 && d == prev_q) ? sat_inc(eq_q) : 8'd1;
    zero_d = (d == 8'd0) ? sat_inc(zero_q) : 8'd0;
    prev_d = d;
    pos_d  = next_pos[PW-1:0];
  end

  // strip check on the final byte
  always_comb begin
    trim = 8'd0;
    if (cfg_i.direction == bpad_pkg::DIR_STRIP && last && d != 8'd0 && d <= seen_d) begin
      case (cfg_i.pad_scheme)
        bpad_pkg::SCH_ANSI:  trim = (zero_q >= d - 8'd1) ? d : 8'd0;
        bpad_pkg::SCH_PKCS7: trim = (eq_d >= d) ? d : 8'd0;
        bpad_pkg::SCH_ISO:   trim = d;
        default:             trim = 8'd0;
      endcase
    end
  end

  // command for the back end
  always_comb begin
    pad                = cfg_i.direction == bpad_pkg::DIR_PAD && last && next_pos != 7'd0;
    cmd_o.data_byte    = d;
    cmd_o.out_last     = last && !pad;
    cmd_o.trim_count   = trim;
    cmd_o.fill_cnt     = pad ? fill_len[PW-1:0] : '0;
    cmd_o.pad_scheme   = cfg_i.pad_scheme;
  end

  // message state, cleared after each final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      seen_q <= '0;
      prev_q <= '0;
      eq_q   <= '0;
      zero_q <= '0;
    end else if (push_o) begin
      if (last) begin
        pos_q  <= '0;
        seen_q <= '0;
        prev_q <= '0;
        eq_q   <= '0;
        zero_q <= '0;
      end else begin
        pos_q  <= pos_d;
        seen_q <= seen_d;
        prev_q <= prev_d;
        eq_q   <= eq_d;
        zero_q <= zero_d;
      end
    end
  end

endmodule

// ===== src/bpad_queue.sv =====
// two-entry command queue between front and back
module bpad_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bpad_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output bpad_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  bpad_pkg::cmd_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign head_o  = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== src/bpad_back.sv =====
// back end: emits the item and its fill bytes into the output register
module bpad_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                seed_we_i,
  input  logic [15:0]         seed_i,
  input  bpad_pkg::cmd_t      cmd_i,
  input  logic                cmd_valid_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bpad_pkg::out_item_t out_item_o
);

  localparam int unsigned PW = bpad_pkg::POS_W;

  logic [PW-1:0]       step_q;
  logic [15:0]         lfsr_q;
  logic [15:0]         lfsr_next;
  logic                out_valid_q;
  bpad_pkg::out_item_t out_q, out_d;
  logic                fire;
  logic                final_step;
  logic                take_rand;
  logic [7:0]          cnt_byte;

  assign fire        = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign final_step  = step_q == cmd_i.fill_cnt;
  assign pop_o       = fire && final_step;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign cnt_byte    = 8'(cmd_i.fill_cnt);
  assign lfsr_next   = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? bpad_pkg::LFSR_TAPS : 16'h0000);
  assign take_rand   = step_q != '0 && !final_step && cmd_i.pad_scheme == bpad_pkg::SCH_ISO;

  // result for the current step
  always_comb begin
    out_d.trim_count = 8'd0;
    if (step_q == '0) begin
      out_d.out_byte   = cmd_i.data_byte;
      out_d.out_last   = cmd_i.out_last;
      out_d.is_fill    = 1'b0;
      out_d.trim_count = cmd_i.trim_count;
    end else begin
      out_d.out_last = final_step;
      out_d.is_fill  = 1'b1;
      case (cmd_i.pad_scheme)
        bpad_pkg::SCH_ZERO:  out_d.out_byte = 8'd0;
        bpad_pkg::SCH_ANSI:  out_d.out_byte = final_step ? cnt_byte : 8'd0;
        bpad_pkg::SCH_PKCS7: out_d.out_byte = cnt_byte;
        bpad_pkg::SCH_ISO:   out_d.out_byte = final_step ? cnt_byte : lfsr_next[7:0];
        default:             out_d.out_byte = 8'd0;
      endcase
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  // step counter, output valid and random fill generator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
      lfsr_q      <= 16'h0001;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        step_q      <= final_step ? '0 : step_q + PW'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (seed_we_i) begin
        lfsr_q <= (seed_i == 16'h0000) ? 16'h0001 : seed_i;
      end else if (fire && take_rand) begin
        lfsr_q <= lfsr_next;
      end
    end
  end

endmodule

// ===== src/bpad_check.sv =====
// port-level assertion checker for the block padding unit, with its bind
`include "block_padding_pad_strip_assert.svh"

module bpad_check (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input bpad_pkg::out_item_t out_item_o
);

  // a stalled result keeps its payload
  `BPAD_ASSERT_HOLD(a_out_hold, out_valid_o, out_ready_i, out_item_o, "output changed while stalled")

  // a trim is only reported on the final result, never on fill
  `BPAD_ASSERT(a_trim_last, out_valid_o && out_item_o.trim_count != 8'd0 |-> out_item_o.out_last && !out_item_o.is_fill, "trim on a non-final or fill result")

  // a reported trim equals the final byte value
  `BPAD_ASSERT(a_trim_value, out_valid_o && out_item_o.trim_count != 8'd0 |-> out_item_o.trim_count == out_item_o.out_byte, "trim differs from final byte")

  // no result is offered during reset
  `BPAD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind block_padding_pad_strip bpad_check u_bpad_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
